// ----- hw/rtl/multi_context_request_queue_defines.svh -----
// Assertion macros shared by the request queue RTL.
`ifndef MULTI_CONTEXT_REQUEST_QUEUE_DEFINES_SVH
`define MULTI_CONTEXT_REQUEST_QUEUE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MCRQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MCRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mcrq_pkg.sv -----
// Types and constants for the multi-context request queue.
`default_nettype none

package mcrq_pkg;

    localparam int CTX_W        = 3;
    localparam int TAG_W        = 6;
    localparam int NUM_CONTEXTS = 1 << CTX_W;
    localparam int NUM_TAGS     = 1 << TAG_W;

    localparam logic [1:0] MODE_TAIL     = 2'd0;
    localparam logic [1:0] MODE_HEAD     = 2'd1;
    localparam logic [1:0] MODE_DISPATCH = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CTX_W-1:0] context_index;
        logic [TAG_W-1:0] request_tag;
    } t_item;

    typedef struct packed {
        logic             dispatched_valid;
        logic [TAG_W-1:0] dispatched_tag;
        logic             work_pending;
    } t_result;

    typedef struct packed {
        logic capture;
        logic insert;
        logic pop;
        logic load_head;
        logic splice_step;
        logic emit_idle;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       nonempty;
        logic       ready_any;
        logic       pop_more;
        logic       scan_last;
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/mcrq_ctrl.sv -----
// Sequencer for the request queue: decode, splice scan, pop and head reload.
`default_nettype none

`include "multi_context_request_queue_defines.svh"

module mcrq_ctrl
    import mcrq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_SPLICE = 2'd2;
    localparam logic [1:0] S_LOAD   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.mode == MODE_TAIL || i_sts.mode == MODE_HEAD) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.mode == MODE_DISPATCH) begin
                    if (i_sts.nonempty) begin
                        o_cmd.pop = 1'b1;
                        n_state   = i_sts.pop_more ? S_LOAD : S_IDLE;
                    end else if (i_sts.ready_any) begin
                        n_state = S_SPLICE;
                    end else begin
                        o_cmd.emit_idle = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.emit_idle = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SPLICE: begin
                o_cmd.splice_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DECODE;
                end
            end
            S_LOAD: begin
                o_cmd.load_head = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MCRQ_ASSERT_IMPL(a_load_follows_pop, r_state == S_LOAD, $past(o_cmd.pop), "head reload without pop")
    `MCRQ_ASSERT_IMPL(a_splice_on_dispatch, r_state == S_SPLICE, i_sts.mode == MODE_DISPATCH, "splice outside dispatch")

endmodule

`default_nettype wire

// ----- hw/rtl/mcrq_dp.sv -----
// Datapath: context lists, link memory, ready map, dispatch queue, result register.
`default_nettype none

`include "multi_context_request_queue_defines.svh"

module mcrq_dp
    import mcrq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire t_cmd  i_cmd,
    output t_sts       o_sts,
    output logic       o_strobe,
    output t_result    o_result
);

    t_item                    r_item;
    logic [TAG_W-1:0]         r_link [NUM_TAGS];
    logic [TAG_W-1:0]         r_rdata;
    logic [TAG_W-1:0]         r_ctx_head [NUM_CONTEXTS];
    logic [TAG_W-1:0]         r_ctx_tail [NUM_CONTEXTS];
    logic [NUM_CONTEXTS-1:0]  r_ready;
    logic [TAG_W-1:0]         r_dhead;
    logic [TAG_W-1:0]         r_dtail;
    logic                     r_dnonempty;
    logic [CTX_W-1:0]         r_scan;
    logic                     r_strobe;
    t_result                  r_res;

    logic [CTX_W-1:0] w_ctx;
    logic [TAG_W-1:0] w_tag;
    logic             w_at_head;
    logic             w_ctx_ready;
    logic             w_scan_ready;
    logic             w_we;
    logic [TAG_W-1:0] w_wa;
    logic [TAG_W-1:0] w_wd;

    assign w_ctx        = r_item.context_index;
    assign w_tag        = r_item.request_tag;
    assign w_at_head    = (r_item.mode == MODE_HEAD);
    assign w_ctx_ready  = r_ready[w_ctx];
    assign w_scan_ready = r_ready[r_scan];

    assign o_sts.mode      = r_item.mode;
    assign o_sts.nonempty  = r_dnonempty;
    assign o_sts.ready_any = (r_ready != '0);
    assign o_sts.pop_more  = (r_dhead != r_dtail);
    assign o_sts.scan_last = (r_scan == CTX_W'(NUM_CONTEXTS - 1));

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // link memory write port
    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        if (i_cmd.insert && w_ctx_ready) begin
            w_we = 1'b1;
            if (w_at_head) begin
                w_wa = w_tag;
                w_wd = r_ctx_head[w_ctx];
            end else begin
                w_wa = r_ctx_tail[w_ctx];
                w_wd = w_tag;
            end
        end else if (i_cmd.splice_step && w_scan_ready && r_dnonempty) begin
            w_we = 1'b1;
            w_wa = r_dtail;
            w_wd = r_ctx_head[r_scan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link[w_wa] <= w_wd;
        end
        r_rdata <= r_link[r_dhead];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.insert) begin
            if (!w_ctx_ready) begin
                r_ctx_head[w_ctx] <= w_tag;
                r_ctx_tail[w_ctx] <= w_tag;
            end else if (w_at_head) begin
                r_ctx_head[w_ctx] <= w_tag;
            end else begin
                r_ctx_tail[w_ctx] <= w_tag;
            end
        end
        if (i_cmd.insert) begin
            r_res.dispatched_valid <= 1'b0;
            r_res.dispatched_tag   <= '0;
            r_res.work_pending     <= 1'b1;
        end else if (i_cmd.pop) begin
            r_res.dispatched_valid <= 1'b1;
            r_res.dispatched_tag   <= r_dhead;
            r_res.work_pending     <= (r_dhead != r_dtail) || (r_ready != '0);
        end else if (i_cmd.emit_idle) begin
            r_res.dispatched_valid <= 1'b0;
            r_res.dispatched_tag   <= '0;
            r_res.work_pending     <= r_dnonempty || (r_ready != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= '0;
            r_dhead     <= '0;
            r_dtail     <= '0;
            r_dnonempty <= 1'b0;
            r_scan      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= i_cmd.insert || i_cmd.pop || i_cmd.emit_idle;
            if (i_cmd.capture) begin
                r_scan <= '0;
            end else if (i_cmd.splice_step) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.insert) begin
                r_ready[w_ctx] <= 1'b1;
            end
            if (i_cmd.splice_step) begin
                if (w_scan_ready) begin
                    if (!r_dnonempty) begin
                        r_dhead     <= r_ctx_head[r_scan];
                        r_dnonempty <= 1'b1;
                    end
                    r_dtail <= r_ctx_tail[r_scan];
                end
                if (o_sts.scan_last) begin
                    r_ready <= '0;
                end
            end
            if (i_cmd.pop && (r_dhead == r_dtail)) begin
                r_dnonempty <= 1'b0;
            end
            if (i_cmd.load_head) begin
                r_dhead <= r_rdata;
            end
        end
    end

    `MCRQ_ASSERT_NEXT(a_pop_result, i_cmd.pop, r_strobe && r_res.dispatched_valid, "pop gave no tag")
    `MCRQ_ASSERT_NEXT(a_splice_done, i_cmd.splice_step && o_sts.scan_last && (r_ready != '0), (r_ready == '0) && r_dnonempty, "flush left queue empty")

endmodule

`default_nettype wire

// ----- hw/rtl/multi_context_request_queue.sv -----
// A result strobes in the cycle after decode; the path from a transfer runs through the capture
// register, decode and the result register, and a flush adds a scan of every context and a second
// decode before the pop. A pop whose queue holds more tags goes on to reload the head link from the
// link memory. A new request is taken only once the block is idle again (busy low).
// Results cannot be stalled; each strobes for exactly one cycle.
// Reset (synchronous, active low) clears the ready map and dispatch queue; no clearing pass.
`default_nettype none

module multi_context_request_queue
    import mcrq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_item i_item,
    output logic       o_strobe,
    output t_result    o_result
);

    t_cmd w_cmd;
    t_sts w_sts;

    mcrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    mcrq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
